// ----- rtl/round_robin_voice_allocator_assert.svh -----
// assertion macros shared by the voice allocator rtl
// no dependencies; included by the modules that carry checks
`ifndef ROUND_ROBIN_VOICE_ALLOCATOR_ASSERT_SVH
`define ROUND_ROBIN_VOICE_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define RRVA_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define RRVA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define RRVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rrva_pkg.sv -----
// shared types and constants of the round-robin voice allocator
// no dependencies
package rrva_pkg;

  // default voice count
  localparam int unsigned VoicesDef = 24;

  // command codes
  localparam logic CMD_PLAY = 1'b0;
  localparam logic CMD_DONE = 1'b1;

  // random generator and jitter constants
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_ADD   = 32'd1013904223;
  localparam logic [31:0] LCG_SEED  = 32'h4d595df4;
  localparam logic [16:0] JIT_BASE  = 17'd61604;
  localparam logic [31:0] JIT_SPAN  = 32'd7864;

  // clamp limits, q.12
  localparam logic [14:0]        VOL_MAX_W  = 15'd8192;
  localparam logic [13:0]        VOL_MAX    = 14'd8192;
  localparam logic signed [15:0] PAN_HI_W   = 16'sd4096;
  localparam logic signed [15:0] PAN_LO_W   = -16'sd4096;
  localparam logic [13:0]        PAN_HI     = 14'h1000;
  localparam logic [13:0]        PAN_LO     = 14'h3000;
  localparam logic [16:0]        PITCH_MIN_W = 17'd1024;
  localparam logic [16:0]        PITCH_MAX_W = 17'd16384;
  localparam logic [14:0]        PITCH_MIN  = 15'd1024;
  localparam logic [14:0]        PITCH_MAX  = 15'd16384;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LCG_MUL,
    S_LCG_ADD,
    S_JIT_MUL,
    S_JIT_ADD,
    S_PITCH_MUL,
    S_FINISH
  } rrva_state_e;

  // controls into the voice scan unit
  typedef struct packed {
    logic start;
    logic clear;
  } scan_ctrl_t;

  // status out of the voice scan unit
  typedef struct packed {
    logic active;
    logic stolen;
  } scan_stat_t;

endpackage

// ----- rtl/rrva_mul.sv -----
// shared 32x32 multiplier with registered product
// depends on nothing; used by the allocator sequencer
module rrva_mul (
  input  logic        clk_i,
  input  logic        go_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_d, p_q;

  // product is captured only when issued, held otherwise
  always_comb begin
    p_d = p_q;
    if (go_i) begin
      p_d = 64'(a_i) * 64'(b_i);
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/rrva_voice_scan.sv -----
// busy flags, round-robin pointer and a one-voice-per-cycle idle search
// depends on rrva_pkg and the assertion macro header
`include "round_robin_voice_allocator_assert.svh"

module rrva_voice_scan import rrva_pkg::*; #(
  parameter int unsigned VOICES = VoicesDef,
  localparam int unsigned PtrW = $clog2(VOICES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scan_ctrl_t      ctrl_i,
  input  logic [PtrW-1:0] clr_idx_i,
  output scan_stat_t      stat_o,
  output logic [PtrW-1:0] voice_o
);

  localparam logic [PtrW-1:0] LastIdx = PtrW'(VOICES - 1);

  logic [VOICES-1:0] busy_d, busy_q;
  logic [PtrW-1:0]   ptr_d, ptr_q;
  logic [PtrW-1:0]   cand_d, cand_q;
  logic [PtrW-1:0]   cnt_d, cnt_q;
  logic              active_d, active_q;
  logic [PtrW-1:0]   chosen_d, chosen_q;
  logic              stolen_d, stolen_q;
  logic [PtrW-1:0]   cand_inc, ptr_inc;

  // wrap-around increments
  assign cand_inc = (cand_q == LastIdx) ? '0 : cand_q + 1'b1;
  assign ptr_inc  = (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;

  // search one candidate per cycle, steal at the pointer after a full lap
  always_comb begin
    busy_d   = busy_q;
    ptr_d    = ptr_q;
    cand_d   = cand_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    chosen_d = chosen_q;
    stolen_d = stolen_q;
    if (ctrl_i.clear) begin
      busy_d[clr_idx_i] = 1'b0;
    end
    if (ctrl_i.start) begin
      active_d = 1'b1;
      cand_d   = ptr_q;
      cnt_d    = '0;
    end else if (active_q) begin
      if (!busy_q[cand_q]) begin
        busy_d[cand_q] = 1'b1;
        chosen_d       = cand_q;
        stolen_d       = 1'b0;
        ptr_d          = cand_inc;
        active_d       = 1'b0;
      end else if (cnt_q == LastIdx) begin
        chosen_d = ptr_q;
        stolen_d = 1'b1;
        ptr_d    = ptr_inc;
        active_d = 1'b0;
      end else begin
        cand_d = cand_inc;
        cnt_d  = cnt_q + 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      ptr_q    <= '0;
      active_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ptr_q    <= ptr_d;
      active_q <= active_d;
    end
  end

  // search payload
  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    cnt_q    <= cnt_d;
    chosen_q <= chosen_d;
    stolen_q <= stolen_d;
  end

  assign stat_o.active = active_q;
  assign stat_o.stolen = stolen_q;
  assign voice_o       = chosen_q;

  // checks
  `RRVA_ASSERT_ALWAYS(a_ptr_range, clk_i, rst_ni, ptr_q <= LastIdx)
  `RRVA_ASSERT_IMP(a_start_idle, clk_i, rst_ni, ctrl_i.start, !active_q && !ctrl_i.clear)
  `RRVA_ASSERT_NEXT(a_clear_takes, clk_i, rst_ni, ctrl_i.clear, !busy_q[$past(clr_idx_i)])

endmodule

// ----- rtl/round_robin_voice_allocator.sv -----
// top level of the round-robin voice allocator with voice stealing
// depends on rrva_pkg, rrva_mul, rrva_voice_scan and the assertion macro header
//
// usage:
//   input channel (in_valid_i / in_ready_o) takes one word per command.
//   cmd_i = play: search for an idle voice starting at the round-robin
//   pointer, steal the voice at the pointer if all are busy, and return one
//   result word with the voice, stolen flag, clamped volume and pan, and
//   the pitch scaled by a random jitter and clamped.
//   cmd_i = done: clears the busy flag of done_voice_i (ignored when out of
//   range) and returns no word.
//   output channel (out_valid_o / out_ready_i) carries the results from an
//   output register, so a new command is taken while a result waits.
//   a play's result is loaded once the scan has probed k voices
//   (1..VOICES) with its one-voice-per-cycle search and the shared
//   multiplier has run its three products (generator step, jitter,
//   pitch) in parallel with the scan. a new play is taken only in idle,
//   after the last one loads its result; done words one per cycle while idle.
//   if the receiver stalls with a result pending, the next play holds in
//   its final cycle until the output register frees.
//   reset clears all busy flags, sets the pointer to zero and seeds the
//   random generator; no clearing pass is needed.
`include "round_robin_voice_allocator_assert.svh"

module round_robin_voice_allocator import rrva_pkg::*; #(
  parameter int unsigned VOICES = VoicesDef,
  localparam int unsigned VidxW = (VOICES > 32) ? 6 : 5,
  localparam int unsigned PtrW  = $clog2(VOICES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [VidxW-1:0]        done_voice_i,
  input  logic signed [15:0]      volume_in_i,
  input  logic signed [15:0]      pan_in_i,
  input  logic [15:0]             pitch_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VidxW-1:0]        voice_o,
  output logic                    stolen_o,
  output logic [13:0]             volume_out_o,
  output logic signed [13:0]      pan_out_o,
  output logic [14:0]             pitch_out_o
);

  rrva_state_e state_d, state_q;

  logic [31:0] lcg_d, lcg_q;
  logic [16:0] jit_d, jit_q;
  logic [15:0] pitch_d, pitch_q;
  logic [13:0] vol_d, vol_q;
  logic [13:0] pan_d, pan_q;

  logic              out_valid_d, out_valid_q;
  logic [VidxW-1:0]  voice_d, voice_q;
  logic              stolen_d, stolen_q;
  logic [13:0]       vol_out_d, vol_out_q;
  logic [13:0]       pan_out_d, pan_out_q;
  logic [14:0]       pitch_out_d, pitch_out_q;

  logic        in_acc, play_acc, done_acc, done_ok;
  logic        mul_go, lcg_ld, jit_ld, out_ld;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [16:0] prod;
  logic [14:0] pitch_clamp;
  logic [13:0] vol_clamp, pan_clamp;
  logic        pitch_ok;

  scan_ctrl_t      scan_ctrl;
  scan_stat_t      scan_stat;
  logic [PtrW-1:0] scan_voice;

  assign in_acc   = in_valid_i && in_ready_o;
  assign play_acc = in_acc && (cmd_i == CMD_PLAY);
  assign done_acc = in_acc && (cmd_i == CMD_DONE);
  assign done_ok  = {1'b0, done_voice_i} < (VidxW + 1)'(VOICES);

  // shared multiplier
  rrva_mul u_mul (
    .clk_i (clk_i),
    .go_i  (mul_go),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // busy flags and idle search
  rrva_voice_scan #(.VOICES(VOICES)) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .clr_idx_i (done_voice_i[PtrW-1:0]),
    .stat_o    (scan_stat),
    .voice_o   (scan_voice)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (play_acc) state_d = S_LCG_MUL;
      S_LCG_MUL:   state_d = S_LCG_ADD;
      S_LCG_ADD:   state_d = S_JIT_MUL;
      S_JIT_MUL:   state_d = S_JIT_ADD;
      S_JIT_ADD:   state_d = S_PITCH_MUL;
      S_PITCH_MUL: state_d = S_FINISH;
      S_FINISH:    if (out_ld) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, loads, scan controls
  always_comb begin
    in_ready_o      = 1'b0;
    scan_ctrl.start = 1'b0;
    scan_ctrl.clear = 1'b0;
    mul_go          = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    lcg_ld          = 1'b0;
    jit_ld          = 1'b0;
    out_ld          = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        scan_ctrl.start = in_valid_i && (cmd_i == CMD_PLAY);
        scan_ctrl.clear = in_valid_i && (cmd_i == CMD_DONE) && done_ok;
      end
      S_LCG_MUL: begin
        mul_go = 1'b1;
        mul_a  = lcg_q;
        mul_b  = LCG_MUL;
      end
      S_LCG_ADD: begin
        lcg_ld = 1'b1;
      end
      S_JIT_MUL: begin
        mul_go = 1'b1;
        mul_a  = JIT_SPAN;
        mul_b  = {8'h00, lcg_q[31:8]};
      end
      S_JIT_ADD: begin
        jit_ld = 1'b1;
      end
      S_PITCH_MUL: begin
        mul_go = 1'b1;
        mul_a  = {16'h0000, pitch_q};
        mul_b  = {15'h0000, jit_q};
      end
      S_FINISH: begin
        out_ld = !scan_stat.active && (!out_valid_q || out_ready_i);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // volume and pan clamps on the incoming word
  always_comb begin
    if (volume_in_i[15]) begin
      vol_clamp = '0;
    end else if (volume_in_i[14:0] > VOL_MAX_W) begin
      vol_clamp = VOL_MAX;
    end else begin
      vol_clamp = volume_in_i[13:0];
    end
    if (pan_in_i < PAN_LO_W) begin
      pan_clamp = PAN_LO;
    end else if (pan_in_i > PAN_HI_W) begin
      pan_clamp = PAN_HI;
    end else begin
      pan_clamp = pan_in_i[13:0];
    end
  end

  // pitch clamp on the final product
  assign prod = mul_p[32:16];
  always_comb begin
    if (prod < PITCH_MIN_W) begin
      pitch_clamp = PITCH_MIN;
    end else if (prod > PITCH_MAX_W) begin
      pitch_clamp = PITCH_MAX;
    end else begin
      pitch_clamp = prod[14:0];
    end
  end

  // datapath registers
  always_comb begin
    lcg_d   = lcg_ld ? (mul_p[31:0] + LCG_ADD) : lcg_q;
    jit_d   = jit_ld ? (JIT_BASE + {4'h0, mul_p[36:24]}) : jit_q;
    pitch_d = play_acc ? pitch_in_i : pitch_q;
    vol_d   = play_acc ? vol_clamp : vol_q;
    pan_d   = play_acc ? pan_clamp : pan_q;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    voice_d     = voice_q;
    stolen_d    = stolen_q;
    vol_out_d   = vol_out_q;
    pan_out_d   = pan_out_q;
    pitch_out_d = pitch_out_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
      voice_d     = VidxW'(scan_voice);
      stolen_d    = scan_stat.stolen;
      vol_out_d   = vol_q;
      pan_out_d   = pan_q;
      pitch_out_d = pitch_clamp;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and generator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lcg_q       <= LCG_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lcg_q       <= lcg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    jit_q       <= jit_d;
    pitch_q     <= pitch_d;
    vol_q       <= vol_d;
    pan_q       <= pan_d;
    voice_q     <= voice_d;
    stolen_q    <= stolen_d;
    vol_out_q   <= vol_out_d;
    pan_out_q   <= pan_out_d;
    pitch_out_q <= pitch_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign voice_o      = voice_q;
  assign stolen_o     = stolen_q;
  assign volume_out_o = vol_out_q;
  assign pan_out_o    = pan_out_q;
  assign pitch_out_o  = pitch_out_q;

  // held pitch lies inside the clamp window
  assign pitch_ok = (pitch_out_q >= PITCH_MIN) && (pitch_out_q <= PITCH_MAX);

  // checks
  `RRVA_ASSERT_IMP(a_idle_scan_done, clk_i, rst_ni, state_q == S_IDLE, !scan_stat.active)
  `RRVA_ASSERT_NEXT(a_done_keeps_lcg, clk_i, rst_ni, done_acc, $stable(lcg_q))
  `RRVA_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, out_valid_q, pitch_ok)

endmodule
